// ===== src/sbpm_pkg.sv =====
// Shared types, codes and constants for the servo bus packet master.
`default_nettype none

package sbpm_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_MOVE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_RX   = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_POS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING       = 2'd2;
  localparam int CFG_DATA_W = 12;

  // Register reset values
  localparam logic [7:0]  SERVO_ID_RST    = 8'd1;
  localparam logic [11:0] DEFAULT_POS_RST = 12'd2048;
  localparam logic [11:0] SWING_RST       = 12'd512;
  localparam logic [15:0] LAST_POS_RST    = 16'd2048;

  // Report status codes
  localparam logic [1:0] STATUS_FRESH   = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
  localparam logic [1:0] STATUS_BAD_HDR = 2'd2;

  // Result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Packet constants
  localparam logic [7:0]  PKT_HDR       = 8'hFF;
  localparam logic [7:0]  LEN_WRITE     = 8'h05;
  localparam logic [7:0]  LEN_READ      = 8'h04;
  localparam logic [7:0]  INSTR_WRITE   = 8'h03;
  localparam logic [7:0]  INSTR_READ    = 8'h02;
  localparam logic [7:0]  REG_GOAL_POS  = 8'h2A;
  localparam logic [7:0]  REG_PRES_POS  = 8'h38;
  localparam logic [7:0]  READ_SIZE     = 8'h02;
  localparam logic [11:0] POS_MAX       = 12'd4095;

  // Reply byte positions
  localparam int REPLY_CNT_W = 3;
  localparam logic [REPLY_CNT_W-1:0] RPL_HDR0 = 3'd0;
  localparam logic [REPLY_CNT_W-1:0] RPL_HDR1 = 3'd1;
  localparam logic [REPLY_CNT_W-1:0] RPL_ID   = 3'd2;
  localparam logic [REPLY_CNT_W-1:0] RPL_LEN  = 3'd3;
  localparam logic [REPLY_CNT_W-1:0] RPL_POSL = 3'd5;
  localparam logic [REPLY_CNT_W-1:0] RPL_POSH = 3'd6;
  localparam logic [REPLY_CNT_W-1:0] RPL_LAST = 3'd7;

  localparam int TICK_W = 8;
  localparam int TIMEOUT_TICKS_DEF = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Job kinds handed from front to back
  localparam logic [1:0] JOB_MOVE   = 2'd0;
  localparam logic [1:0] JOB_READ   = 2'd1;
  localparam logic [1:0] JOB_REPORT = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] position_cmd;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [15:0] position;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  servo_id;
    logic [15:0] position;
    logic [1:0]  status;
  } job_t;

endpackage

`default_nettype wire

// ===== src/sbpm_front.sv =====
// Front end: config registers, move clamping and reply collection; emits jobs.
`default_nettype none

module sbpm_front
  import sbpm_pkg::*;
#(
  parameter int TIMEOUT_TICKS = TIMEOUT_TICKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire in_t                   request,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       job_push,
  output job_t                       job
);

  logic [7:0]             servo_id;
  logic [11:0]            default_pos;
  logic [11:0]            swing;

  logic                   awaiting;
  logic                   awaiting_next;
  logic [REPLY_CNT_W-1:0] reply_count;
  logic [REPLY_CNT_W-1:0] reply_count_next;
  logic [TICK_W-1:0]      tick_count;
  logic [TICK_W-1:0]      tick_count_next;
  logic                   header_ok;
  logic                   header_ok_next;
  logic [7:0]             pos_lo;
  logic [7:0]             pos_lo_next;
  logic [7:0]             pos_hi;
  logic [7:0]             pos_hi_next;
  logic [15:0]            last_pos;
  logic [15:0]            last_pos_next;

  logic [11:0]            win_lo;
  logic [12:0]            win_sum;
  logic [11:0]            win_hi;
  logic [11:0]            clamped;
  logic [TICK_W-1:0]      tick_inc;

  // Move window
  always_comb begin
    win_lo  = (default_pos > swing) ? default_pos - swing : 12'd0;
    win_sum = {1'b0, default_pos} + {1'b0, swing};
    win_hi  = (win_sum > {1'b0, POS_MAX}) ? POS_MAX : win_sum[11:0];
    clamped = request.position_cmd;
    if (clamped < win_lo) clamped = win_lo;
    if (clamped > win_hi) clamped = win_hi;
  end

  assign tick_inc = (tick_count != '1) ? tick_count + 1'b1 : tick_count;

  always_comb begin
    awaiting_next    = awaiting;
    reply_count_next = reply_count;
    tick_count_next  = tick_count;
    header_ok_next   = header_ok;
    pos_lo_next      = pos_lo;
    pos_hi_next      = pos_hi;
    last_pos_next    = last_pos;
    job_push         = 1'b0;
    job.kind         = JOB_MOVE;
    job.servo_id     = servo_id;
    job.position     = {4'd0, clamped};
    job.status       = STATUS_FRESH;

    if (accept) begin
      unique case (request.operation)
        OP_MOVE: begin
          job_push = 1'b1;
        end
        OP_READ: begin
          job_push         = 1'b1;
          job.kind         = JOB_READ;
          awaiting_next    = 1'b1;
          reply_count_next = '0;
          tick_count_next  = '0;
          header_ok_next   = 1'b1;
        end
        OP_RX: begin
          if (awaiting) begin
            unique case (reply_count)
              RPL_HDR0, RPL_HDR1: begin
                if (request.rx_byte != PKT_HDR) header_ok_next = 1'b0;
              end
              RPL_ID: begin
                if (request.rx_byte != servo_id) header_ok_next = 1'b0;
              end
              RPL_LEN: begin
                if (request.rx_byte != LEN_READ) header_ok_next = 1'b0;
              end
              RPL_POSL: pos_lo_next = request.rx_byte;
              RPL_POSH: pos_hi_next = request.rx_byte;
              default: ;
            endcase
            if (reply_count == RPL_LAST) begin
              job_push         = 1'b1;
              job.kind         = JOB_REPORT;
              awaiting_next    = 1'b0;
              reply_count_next = '0;
              tick_count_next  = '0;
              if (header_ok) begin
                last_pos_next = {pos_hi, pos_lo};
                job.position  = {pos_hi, pos_lo};
                job.status    = STATUS_FRESH;
              end else begin
                job.position = last_pos;
                job.status   = STATUS_BAD_HDR;
              end
            end else begin
              reply_count_next = reply_count + 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (awaiting) begin
            tick_count_next = tick_inc;
            if (tick_inc >= TICK_W'(TIMEOUT_TICKS)) begin
              job_push         = 1'b1;
              job.kind         = JOB_REPORT;
              job.position     = last_pos;
              job.status       = STATUS_TIMEOUT;
              awaiting_next    = 1'b0;
              reply_count_next = '0;
              tick_count_next  = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id    <= SERVO_ID_RST;
      default_pos <= DEFAULT_POS_RST;
      swing       <= SWING_RST;
      awaiting    <= 1'b0;
      reply_count <= '0;
      tick_count  <= '0;
      header_ok   <= 1'b1;
      last_pos    <= LAST_POS_RST;
    end else begin
      awaiting    <= awaiting_next;
      reply_count <= reply_count_next;
      tick_count  <= tick_count_next;
      header_ok   <= header_ok_next;
      last_pos    <= last_pos_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SERVO_ID:    servo_id    <= cfg_data[7:0];
          CFG_DEFAULT_POS: default_pos <= cfg_data;
          CFG_SWING:       swing       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Reply payload bytes; only read after being written in the same reply
  always_ff @(posedge clk) begin
    pos_lo <= pos_lo_next;
    pos_hi <= pos_hi_next;
  end

endmodule

`default_nettype wire

// ===== src/sbpm_job_queue.sv =====
// Small job queue between front end and packet back end.
`default_nettype none

module sbpm_job_queue
  import sbpm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/sbpm_back.sv =====
// Back end: serializes jobs into packet bytes and reports, with checksum.
`default_nettype none

module sbpm_back
  import sbpm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_avail,
  output logic      job_pop,
  output out_t      result,
  output logic      empty,
  input  wire logic pop
);

  logic [3:0] idx;
  logic [7:0] sum;
  logic       out_valid;
  logic       advance;
  logic       beat_last;
  out_t       beat;

  assign empty   = !out_valid;
  assign advance = job_avail && (!out_valid || pop);
  assign job_pop = advance && beat_last;

  always_comb begin
    beat.kind      = KIND_TX;
    beat.tx_byte   = 8'd0;
    beat.last_byte = 1'b0;
    beat.position  = 16'd0;
    beat.status    = STATUS_FRESH;
    beat_last      = 1'b0;
    unique case (job.kind)
      JOB_MOVE: begin
        unique case (idx)
          4'd0, 4'd1: beat.tx_byte = PKT_HDR;
          4'd2:       beat.tx_byte = job.servo_id;
          4'd3:       beat.tx_byte = LEN_WRITE;
          4'd4:       beat.tx_byte = INSTR_WRITE;
          4'd5:       beat.tx_byte = REG_GOAL_POS;
          4'd6:       beat.tx_byte = job.position[7:0];
          4'd7:       beat.tx_byte = job.position[15:8];
          default: begin
            beat.tx_byte = ~sum;
            beat_last    = 1'b1;
          end
        endcase
      end
      JOB_READ: begin
        unique case (idx)
          4'd0, 4'd1: beat.tx_byte = PKT_HDR;
          4'd2:       beat.tx_byte = job.servo_id;
          4'd3:       beat.tx_byte = LEN_READ;
          4'd4:       beat.tx_byte = INSTR_READ;
          4'd5:       beat.tx_byte = REG_PRES_POS;
          4'd6:       beat.tx_byte = READ_SIZE;
          default: begin
            beat.tx_byte = ~sum;
            beat_last    = 1'b1;
          end
        endcase
      end
      default: begin
        beat.kind     = KIND_REPORT;
        beat.position = job.position;
        beat.status   = job.status;
        beat_last     = 1'b1;
      end
    endcase
    beat.last_byte = beat_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (beat_last) begin
          idx <= '0;
          sum <= '0;
        end else begin
          idx <= idx + 1'b1;
          // checksum covers everything after the two header bytes
          if (idx >= 4'd2) sum <= sum + beat.tx_byte;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= beat;
  end

endmodule

`default_nettype wire

// ===== src/servo_bus_packet_master.sv =====
// Top level of the servo bus packet master: front end, job queue, back end.
//
//  channel   handshake           payload
//  --------  ------------------  ------------------------------------------
//  request   push / full         in_t: operation, position_cmd, rx_byte
//  result    empty / pop         out_t: kind, tx_byte, last_byte, position,
//                                status
//  config    cfg_write           cfg_index, cfg_data (servo_id, default
//                                position, swing)
//
// A request beat is taken every cycle while the job queue has room. A move
// turns into 9 result beats, a read into 8, a finished or timed-out reply
// into one report; the back end emits one beat per cycle while a job waits and
// pop keeps up, so its byte counter sets the sustained rate. Bytes and ticks
// that produce no result are handled in the front end only. Reset is synchronous.
// A stalled pop holds the result register and, once the queue fills, raises full.
`default_nettype none

module servo_bus_packet_master
  import sbpm_pkg::*;
#(
  parameter int TIMEOUT_TICKS = TIMEOUT_TICKS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_t                   request,
  output logic                       empty,
  input  wire logic                  pop,
  output out_t                       result,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic accept;
  logic job_push;
  job_t front_job;
  job_t head_job;
  logic job_pop;
  logic queue_empty;

  assign accept = push && !full;

  sbpm_front #(
    .TIMEOUT_TICKS(TIMEOUT_TICKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (front_job)
  );

  // Jobs only enter on accepted beats, and accepts need a free slot.
  sbpm_job_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (front_job),
    .rd_en  (job_pop),
    .rd_job (head_job),
    .full   (full),
    .empty  (queue_empty)
  );

  sbpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_avail (!queue_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire
